// ===== rtl/wildcard_pattern_matcher_defines.svh =====
// assertion macros used by the checker file
`ifndef WILDCARD_PATTERN_MATCHER_DEFINES_SVH
`define WILDCARD_PATTERN_MATCHER_DEFINES_SVH

// same-cycle implication, sampled on clk, idle during reset
`define WPM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, idle during reset
`define WPM_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/wpm_pkg.sv =====
package wpm_pkg;

	// default pattern store depth
	localparam int PATTERN_MAX_DEF = 64;

	// pattern wildcard symbols
	localparam logic [7:0] SYM_STAR = 8'd42;
	localparam logic [7:0] SYM_ANY  = 8'd63;

	// request codes
	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_TEXT   = 2'd1;
	localparam logic [1:0] REQ_REPORT = 2'd2;

	// request beat
	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] symbol;
		logic       first_of_pattern;
	} wpm_req_t;

	// response beat
	typedef struct packed {
		logic matched;
		logic pattern_overflow;
	} wpm_rsp_t;

	// broadcast control from the top level to every cell
	typedef struct packed {
		logic       load;
		logic       store;
		logic       first;
		logic       text;
		logic       restart;
		logic [7:0] sym;
	} wpm_ctl_t;

	// link from one cell to its right-hand neighbour
	typedef struct packed {
		logic step;
		logic chain;
		logic lead;
		logic wr;
	} wpm_link_t;

endpackage

// ===== rtl/wpm_cell.sv =====
module wpm_cell #(
	parameter int PATTERN_MAX = wpm_pkg::PATTERN_MAX_DEF,
	parameter int IDX         = 0
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  wpm_pkg::wpm_ctl_t                  ctl,
	input  logic [$clog2(PATTERN_MAX+1)-1:0]   wr_idx,
	input  wpm_pkg::wpm_link_t                 left,
	output wpm_pkg::wpm_link_t                 right,
	output logic                               active
);
	import wpm_pkg::*;

	localparam int LEN_W = $clog2(PATTERN_MAX + 1);

	logic [7:0] sym_q;
	logic       used_q;
	logic       lead_q;
	logic       act_q;

	logic wr;
	logic is_star;
	logic is_any;
	logic next;
	logic lead_d;
	logic used_d;
	logic act_d;

	// symbol decode
	assign wr      = ctl.store & (wr_idx == LEN_W'(IDX));
	assign is_star = (sym_q == SYM_STAR);
	assign is_any  = (sym_q == SYM_ANY);

	// active bit after one text byte, star closure rippling from the left
	assign next = (act_q & used_q & is_star) | left.step | left.chain;

	// start-of-text bit: position zero plus what leading stars reach
	always_comb begin
		lead_d = lead_q;
		if (IDX == 0) begin
			lead_d = 1'b1;
		end else if (ctl.load) begin
			if (left.wr) begin
				lead_d = left.lead & (ctl.sym == SYM_STAR);
			end else if (ctl.first) begin
				lead_d = 1'b0;
			end
		end
	end

	// occupancy of this pattern slot
	always_comb begin
		used_d = used_q;
		if (ctl.store) begin
			used_d = wr | (used_q & ~ctl.first);
		end
	end

	// active bit update
	always_comb begin
		act_d = act_q;
		if (ctl.restart) begin
			act_d = lead_d;
		end else if (ctl.text) begin
			act_d = next;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			lead_q <= (IDX == 0);
			act_q  <= (IDX == 0);
		end else begin
			used_q <= used_d;
			lead_q <= lead_d;
			act_q  <= act_d;
		end
	end

	// stored pattern symbol
	always_ff @(posedge clk) begin
		if (wr) begin
			sym_q <= ctl.sym;
		end
	end

	// hand-off to the next cell
	assign right.step  = act_q & used_q & ~is_star & (is_any | (sym_q == ctl.sym));
	assign right.chain = next & used_q & is_star;
	assign right.lead  = lead_d;
	assign right.wr    = wr;
	assign active      = act_q;

endmodule

// ===== rtl/wildcard_pattern_matcher.sv =====
// Wildcard pattern matcher: '?' matches any one byte, '*' matches any run.
// Request channel (req_valid / req_stall / req) carries three kinds of beat:
//   load  - stores one pattern symbol; first_of_pattern starts a new pattern
//   text  - advances the match by one text byte
//   report- ends the text and returns one response beat
// Response channel (rsp_valid / rsp_stall / rsp) carries matched and
// pattern_overflow, only for report beats.
// One beat per cycle is accepted while req_stall is low, any mix.
// A report's response is visible in the cycle after it is accepted.
// The rate is set by the row of pattern cells: each holds one symbol and
// one active bit, and the star closure ripples through the whole row within
// the cycle of a text byte.
// A pattern longer than PATTERN_MAX symbols drops the excess and reports
// overflow with no match. Any load or report restarts the text.
// Reset leaves an empty pattern, position zero active and no response held.
// While a response is held under rsp_stall, req_stall is raised and the
// response beat stays unchanged.
module wildcard_pattern_matcher #(
	parameter int PATTERN_MAX = wpm_pkg::PATTERN_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  wpm_pkg::wpm_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output wpm_pkg::wpm_rsp_t rsp
);
	import wpm_pkg::*;

	localparam int LEN_W = $clog2(PATTERN_MAX + 1);

	logic [LEN_W-1:0] len_q;
	logic             ovf_q;
	logic             end_lead_q;
	logic             end_act_q;
	logic             rsp_valid_q;
	wpm_rsp_t         rsp_q;

	logic             accept;
	logic             report;
	logic             full;
	logic             hit;
	logic             end_lead_d;
	logic             end_act_d;
	logic             end_next;
	logic [LEN_W-1:0] wr_idx;
	wpm_ctl_t         ctl;
	wpm_link_t        link [PATTERN_MAX+1];
	logic [PATTERN_MAX:0] act_vec;

	// request decode
	assign req_stall = rsp_valid_q & rsp_stall;
	assign accept    = req_valid & ~req_stall;
	assign report    = accept & (req.req_type == REQ_REPORT);
	assign full      = (len_q == LEN_W'(PATTERN_MAX));
	assign wr_idx    = req.first_of_pattern ? '0 : len_q;

	always_comb begin
		ctl.load    = accept & (req.req_type == REQ_LOAD);
		ctl.store   = ctl.load & (req.first_of_pattern | ~full);
		ctl.first   = req.first_of_pattern;
		ctl.text    = accept & (req.req_type == REQ_TEXT);
		ctl.restart = ctl.load | report;
		ctl.sym     = req.symbol;
	end

	// row of pattern cells
	assign link[0] = '0;

	for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
		wpm_cell #(
			.PATTERN_MAX (PATTERN_MAX),
			.IDX         (g)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.wr_idx (wr_idx),
			.left   (link[g]),
			.right  (link[g+1]),
			.active (act_vec[g])
		);
	end

	// final position, past the last cell
	assign end_next = link[PATTERN_MAX].step | link[PATTERN_MAX].chain;

	always_comb begin
		end_lead_d = end_lead_q;
		if (ctl.load) begin
			if (link[PATTERN_MAX].wr) begin
				end_lead_d = link[PATTERN_MAX].lead & (ctl.sym == SYM_STAR);
			end else if (ctl.first) begin
				end_lead_d = 1'b0;
			end
		end
	end

	always_comb begin
		end_act_d = end_act_q;
		if (ctl.restart) begin
			end_act_d = end_lead_d;
		end else if (ctl.text) begin
			end_act_d = end_next;
		end
	end

	assign act_vec[PATTERN_MAX] = end_act_q;

	// match at the pattern end
	assign hit = act_vec[len_q] & ~ovf_q;

	// pattern length, overflow and final position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			ovf_q      <= 1'b0;
			end_lead_q <= 1'b0;
			end_act_q  <= 1'b0;
		end else begin
			end_lead_q <= end_lead_d;
			end_act_q  <= end_act_d;
			if (ctl.load) begin
				if (req.first_of_pattern) begin
					len_q <= LEN_W'(1);
					ovf_q <= 1'b0;
				end else if (full) begin
					ovf_q <= 1'b1;
				end else begin
					len_q <= len_q + LEN_W'(1);
				end
			end
		end
	end

	// response output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (report) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (report) begin
			rsp_q.matched          <= hit;
			rsp_q.pattern_overflow <= ovf_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/wpm_checker.sv =====
`include "wildcard_pattern_matcher_defines.svh"

module wpm_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input wpm_pkg::wpm_req_t req,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input wpm_pkg::wpm_rsp_t rsp
);
	import wpm_pkg::*;

	// a held response beat keeps its payload
	`WPM_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "rsp beat changed while stalled")

	// a match is never reported for an overflowed pattern
	`WPM_ASSERT_IMP(a_no_match_on_ovf, rsp_valid, !(rsp.matched && rsp.pattern_overflow), "match reported with overflow")

	// a new response only follows an accepted report beat
	`WPM_ASSERT_IMP(a_rsp_from_report, $rose(rsp_valid), $past(req_valid && !req_stall && req.req_type == REQ_REPORT), "response without report")

	// requests are held back only by a stalled response
	`WPM_ASSERT_IMP(a_stall_cause, req_stall, rsp_valid && rsp_stall, "req_stall without stalled response")

endmodule

bind wildcard_pattern_matcher wpm_checker u_wpm_checker (.*);
